// ===== rtl/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants of the streaming literal find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

	localparam int MAX_PATTERN_BYTES     = 8;
	localparam int MAX_REPLACEMENT_BYTES = 8;

	// Widths derived from the limits
	localparam int BYTES_W   = 64;   // packed pattern / replacement register
	localparam int LEN_W     = 4;    // length register fields
	localparam int COUNT_W   = 3;    // held count and beat position, 0..7
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 4'd3;

	// One input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} text_beat_t;

	// One output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       run_last;
		logic       text_end;
	} result_beat_t;

	// Outcome of one input byte: a burst of bytes to send and the new held count
	typedef struct packed {
		logic                emit;    // a burst follows from this byte
		logic [BYTES_W-1:0]  data;    // burst bytes, first in bits 7..0
		logic [COUNT_W-1:0]  cnt_m1;  // burst length minus one
		logic                bare;    // single beat with no byte
		logic                last;    // burst ends the text
		logic [COUNT_W-1:0]  next_k;  // held pattern bytes after this byte
	} step_t;

endpackage : lfr_pkg

`default_nettype wire

// ===== rtl/lfr_match.sv =====
// ----------------------------------------------------------------------------
// lfr_match
// Match step for one text byte: extends the partial match, completes it, or
// falls back KMP-style using parallel prefix/suffix compares.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_match (
	input  wire logic [lfr_pkg::BYTES_W-1:0] pattern_bytes,
	input  wire logic [lfr_pkg::LEN_W-1:0]   pattern_length,
	input  wire logic [lfr_pkg::BYTES_W-1:0] replacement_bytes,
	input  wire logic [lfr_pkg::LEN_W-1:0]   replacement_length,
	input  wire logic [lfr_pkg::COUNT_W-1:0] held_count,
	input  wire lfr_pkg::text_beat_t         beat,
	output lfr_pkg::step_t                   step
);
	import lfr_pkg::*;

	logic [LEN_W-1:0]   plen;
	logic [LEN_W-1:0]   rlen;
	logic [COUNT_W-1:0] k;
	logic [COUNT_W-1:0] plen_m1;
	logic [7:0]         pat_k;
	logic [BYTES_W-1:0] seq;
	logic [BYTES_W-1:0] tail;
	logic [BYTES_W-1:0] mask;
	logic [LEN_W-1:0]   sh;
	logic [MAX_PATTERN_BYTES:1] eq;
	logic [COUNT_W-1:0] j;
	logic               hit;
	logic               done;

	// Effective lengths and held count
	always_comb begin
		if (pattern_length == '0) begin
			plen = LEN_W'(1);
		end else if (pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
			plen = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			plen = pattern_length;
		end
		if (replacement_length > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
			rlen = LEN_W'(MAX_REPLACEMENT_BYTES);
		end else begin
			rlen = replacement_length;
		end
		plen_m1 = COUNT_W'(plen - LEN_W'(1));
		k       = (held_count > plen_m1) ? plen_m1 : held_count;
	end

	// Held bytes followed by the new byte
	always_comb begin
		pat_k = pattern_bytes[{k, 3'b000} +: 8];
		seq   = pattern_bytes;
		seq[{k, 3'b000} +: 8] = beat.text_byte;
		hit   = (pat_k == beat.text_byte);
		done  = ({1'b0, k} + LEN_W'(1)) == plen;
	end

	// Fallback candidates: suffix of length jj of seq against pattern prefix
	always_comb begin
		eq   = '0;
		sh   = '0;
		tail = '0;
		mask = '0;
		for (int jj = 1; jj <= MAX_PATTERN_BYTES; jj++) begin
			sh   = LEN_W'({1'b0, k}) + LEN_W'(1) - LEN_W'(jj);
			tail = seq >> {sh, 3'b000};
			mask = {BYTES_W{1'b1}} >> (7'(BYTES_W) - 7'(8 * jj));
			eq[jj] = (LEN_W'(jj) <= LEN_W'({1'b0, k}))
			      && (((tail ^ pattern_bytes) & mask) == '0);
		end
	end

	// Longest matching suffix wins
	always_comb begin
		j = '0;
		for (int jj = 1; jj <= MAX_PATTERN_BYTES; jj++) begin
			if (eq[jj]) begin
				j = COUNT_W'(jj);
			end
		end
	end

	// Burst descriptor
	always_comb begin
		step.emit   = 1'b0;
		step.data   = seq;
		step.cnt_m1 = k;
		step.bare   = 1'b0;
		step.last   = beat.text_last;
		step.next_k = '0;
		if (hit && done) begin
			// Full match: replacement; if it is empty, a bare end marker at end of text, else nothing
			if (rlen == '0) begin
				step.emit   = beat.text_last;
				step.bare   = 1'b1;
				step.data   = '0;
				step.cnt_m1 = '0;
			end else begin
				step.emit   = 1'b1;
				step.data   = replacement_bytes;
				step.cnt_m1 = COUNT_W'(rlen - LEN_W'(1));
			end
		end else if (hit) begin
			// Partial match grows; flushed whole at end of text
			step.emit   = beat.text_last;
			step.next_k = beat.text_last ? '0 : k + COUNT_W'(1);
		end else if (beat.text_last) begin
			// Mismatch at end: release held bytes and the new one
			step.emit = 1'b1;
		end else begin
			// Mismatch: release what can no longer start a match
			step.emit   = 1'b1;
			step.cnt_m1 = k - j;
			step.next_k = j;
		end
	end

endmodule : lfr_match

`default_nettype wire

// ===== rtl/literal_find_replace_stream_core.sv =====
// ----------------------------------------------------------------------------
// literal_find_replace_stream_core
// Streaming literal find-and-replace over a byte stream.
//
//   channel   direction  handshake         payload
//   in        input      in_valid/stall    text_beat_t   (text_byte, text_last)
//   out       output     out_valid/stall   result_beat_t (byte, flags)
//   cfg       input      cfg_valid/ready   cfg_index, cfg_data
//
// A byte is taken into the input register, matched there combinationally, and its
// result burst loaded into the burst register, which sends one beat a cycle
// while out_stall is low. A burst holds up to 8 beats; while it is being sent, a
// next byte that gives a burst waits in the input register for its last beat.
// A byte that gives no beat retires without using the burst register. The
// input is stalled only while the burst register is still busy. Reset clears
// the held count, valid flags and configuration; pattern length resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_find_replace_stream_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire lfr_pkg::text_beat_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output lfr_pkg::result_beat_t              out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lfr_pkg::BYTES_W-1:0]   cfg_data
);
	import lfr_pkg::*;

	// Configuration registers
	logic [BYTES_W-1:0] pattern_bytes_q;
	logic [LEN_W-1:0]   pattern_length_q;
	logic [BYTES_W-1:0] replacement_bytes_q;
	logic [LEN_W-1:0]   replacement_length_q;

	// Input register
	logic               valid_s1;
	text_beat_t         beat_s1;

	// Match state
	logic [COUNT_W-1:0] k_q;
	step_t              step;

	// Burst register
	logic               busy_q;
	logic [BYTES_W-1:0] data_q;
	logic [COUNT_W-1:0] cnt_m1_q;
	logic [COUNT_W-1:0] pos_q;
	logic               bare_q;
	logic               last_q;

	logic               out_fire;
	logic               last_beat;
	logic               burst_free;
	logic               s1_fire;
	logic               in_fire;

	// Configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= LEN_W'(1);
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Match logic
	lfr_match u_match (
		.pattern_bytes      (pattern_bytes_q),
		.pattern_length     (pattern_length_q),
		.replacement_bytes  (replacement_bytes_q),
		.replacement_length (replacement_length_q),
		.held_count         (k_q),
		.beat               (beat_s1),
		.step               (step)
	);

	// Handshake and advance conditions
	always_comb begin
		out_fire   = busy_q && !out_stall;
		last_beat  = (pos_q == cnt_m1_q);
		burst_free = !busy_q || (out_fire && last_beat);
		s1_fire    = valid_s1 && (!step.emit || burst_free);
		in_stall   = valid_s1 && !s1_fire;
		in_fire    = in_valid && !in_stall;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			k_q      <= '0;
			busy_q   <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				k_q <= step.next_k;
			end
			if (s1_fire && step.emit) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (out_fire && last_beat) begin
				busy_q <= 1'b0;
			end else if (out_fire) begin
				pos_q <= pos_q + COUNT_W'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			beat_s1 <= in_data;
		end
		if (s1_fire && step.emit) begin
			data_q   <= step.data;
			cnt_m1_q <= step.cnt_m1;
			bare_q   <= step.bare;
			last_q   <= step.last;
		end
	end

	// Output beat
	always_comb begin
		out_valid             = busy_q;
		out_data.out_byte     = bare_q ? 8'h00 : data_q[{pos_q, 3'b000} +: 8];
		out_data.byte_present = !bare_q;
		out_data.run_last     = last_beat;
		out_data.text_end     = last_beat && last_q;
	end

`ifndef SYNTHESIS
	// Beat position never passes the end of its burst
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= cnt_m1_q))
		else $error("burst position past burst length");

	// A bare marker only closes a text
	a_bare_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && bare_q) |-> (last_beat && last_q))
		else $error("bare marker not at end of text");

	// Held count is cleared once the final byte retires
	a_last_clears_k: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && beat_s1.text_last) |=> (k_q == '0))
		else $error("held count not cleared at end of text");

	// A burst is never loaded over one still being sent
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && step.emit) |-> burst_free)
		else $error("burst register overwritten");
`endif

endmodule : literal_find_replace_stream_core

`default_nettype wire
